FILE: hw/rtl/fpc_pkg.sv
package fpc_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_VOLUME = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORMAT = 1'b1;

   localparam logic [31:0] ONE_BITS     = 32'h3F80_0000;
   localparam logic [31:0] NEG_ONE_BITS = 32'hBF80_0000;
   localparam logic [31:0] VOLUME_RESET = 32'h3F80_0000;
   localparam logic [31:0] S32_MAX      = 32'h7FFF_FFFF;
   localparam logic [14:0] S16_SCALE    = 15'd32767;

   typedef enum logic [1:0] {
      FMT_U8  = 2'd0,
      FMT_S16 = 2'd1,
      FMT_S32 = 2'd2,
      FMT_F32 = 2'd3
   } fmt_type;

   localparam fmt_type FORMAT_RESET = FMT_S16;

   // raw product of sample and volume, with special-case flags
   typedef struct packed {
      logic               sign;
      logic               nan;
      logic               inf;
      logic               zero;
      logic signed [9:0]  exp_sum;
      logic [47:0]        mant;
   } prod_type;

   function automatic logic [6:0] lead_one(input logic [63:0] n);
      logic [6:0] pos;
      pos = '0;
      for (int i = 0; i < 64; i++) begin
         if (n[i]) begin
            pos = 7'(i);
         end
      end
      return pos;
   endfunction

   // round an integer to 24 significant bits, ties to even, same scale
   function automatic logic [63:0] round_sig24(input logic [63:0] n);
      logic [6:0]  pos;
      logic [5:0]  sh;
      logic [63:0] keep;
      logic [63:0] mask_lo;
      logic        rb;
      logic        sticky;
      logic        inc;
      pos     = lead_one(n);
      sh      = (pos > 7'd23) ? 6'(pos - 7'd23) : 6'd0;
      keep    = n >> sh;
      mask_lo = ~({64{1'b1}} << sh);
      sticky  = |(n & (mask_lo >> 1));
      rb      = |(n & mask_lo & ~(mask_lo >> 1));
      inc     = rb & (sticky | keep[0]);
      return (keep + 64'(inc)) << sh;
   endfunction

endpackage

FILE: hw/rtl/fpc_req_if.sv
interface fpc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample_bits;

   modport source (output valid, output sample_bits, input ready);
   modport sink (input valid, input sample_bits, output ready);
endinterface

FILE: hw/rtl/fpc_rsp_if.sv
interface fpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pcm_word;
   logic [2:0]  byte_count;

   modport source (output valid, output pcm_word, output byte_count, input ready);
   modport sink (input valid, input pcm_word, input byte_count, output ready);
endinterface

FILE: hw/rtl/fpc_mul.sv
module fpc_mul
   import fpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [31:0] sample_bits,
   input  logic [31:0] volume_bits,
   output logic        out_valid,
   input  logic        out_ready,
   output prod_type    prod
);

   logic [7:0]  xe, ve;
   logic [22:0] xf, vf;
   logic        x_nan, x_inf, x_zero, v_nan, v_inf, v_zero;
   logic        en;
   logic        valid_ff;
   prod_type    prod_ff, prod_in;

   assign xe = sample_bits[30:23];
   assign xf = sample_bits[22:0];
   assign ve = volume_bits[30:23];
   assign vf = volume_bits[22:0];

   assign x_nan  = (&xe) & (|xf);
   assign x_inf  = (&xe) & ~(|xf);
   assign x_zero = ~(|xe) & ~(|xf);
   assign v_nan  = (&ve) & (|vf);
   assign v_inf  = (&ve) & ~(|vf);
   assign v_zero = ~(|ve) & ~(|vf);

   always_comb begin
      prod_in.sign    = sample_bits[31] ^ volume_bits[31];
      prod_in.nan     = x_nan | v_nan | (x_inf & v_zero) | (x_zero & v_inf);
      prod_in.inf     = ~prod_in.nan & (x_inf | v_inf);
      prod_in.zero    = ~prod_in.nan & ~prod_in.inf & (x_zero | v_zero);
      // subnormals count with exponent one
      prod_in.exp_sum = $signed({2'b00, (xe == 8'd0) ? 8'd1 : xe})
                      + $signed({2'b00, (ve == 8'd0) ? 8'd1 : ve})
                      - 10'sd254;
      prod_in.mant    = {(|xe), xf} * {(|ve), vf};
   end

   assign en       = ~valid_ff | out_ready;
   assign in_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign prod      = prod_ff;

endmodule

FILE: hw/rtl/fpc_norm.sv
module fpc_norm
   import fpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  prod_type    prod,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [31:0] samp
);

   typedef struct packed {
      logic        sign;
      logic        nan;
      logic        inf;
      logic        zero;
      logic [8:0]  exp_base;
      logic [6:0]  rsh;
      logic [47:0] mant;
   } norm_type;

   logic               en1, en2;
   logic               v1_ff, v2_ff;
   norm_type           norm_ff, norm_in;
   logic [31:0]        samp_ff, samp_in;
   logic [5:0]         lead;
   logic signed [11:0] eb;
   logic signed [11:0] r_full;
   logic [71:0]        wide;
   logic [71:0]        mask_lo;
   logic [71:0]        shifted;
   logic               rb, sticky, inc;
   logic [24:0]        mant_r;
   logic [33:0]        mag;

   // stage one: leading one, result exponent and alignment shift
   always_comb begin
      lead   = 6'(lead_one({16'b0, prod.mant}));
      eb     = 12'(prod.exp_sum) + 12'sd81 + $signed({6'b0, lead});
      r_full = (eb > 12'sd0) ? $signed({6'b0, lead})
                             : $signed({6'b0, lead}) + 12'sd1 - eb;
      norm_in.sign     = prod.sign;
      norm_in.nan      = prod.nan;
      norm_in.inf      = prod.inf;
      norm_in.zero     = prod.zero;
      norm_in.exp_base = (eb > 12'sd0) ? 9'(eb - 12'sd1) : 9'd0;
      norm_in.rsh      = (r_full > 12'sd72) ? 7'd72 : 7'(r_full);
      norm_in.mant     = prod.mant;
   end

   // stage two: round to nearest even, then clamp to the unit range, nan to -1
   always_comb begin
      wide    = {1'b0, norm_ff.mant, 23'b0};
      shifted = wide >> norm_ff.rsh;
      mask_lo = ~({72{1'b1}} << norm_ff.rsh);
      sticky  = |(wide & (mask_lo >> 1));
      rb      = |(wide & mask_lo & ~(mask_lo >> 1));
      inc     = rb & (sticky | shifted[0]);
      mant_r  = shifted[24:0] + 25'(inc);
      mag     = 34'({norm_ff.exp_base, 23'b0}) + 34'(mant_r);
      if (norm_ff.nan) begin
         samp_in = NEG_ONE_BITS;
      end else if (norm_ff.zero) begin
         samp_in = {norm_ff.sign, 31'b0};
      end else if (norm_ff.inf || (mag > 34'(ONE_BITS))) begin
         samp_in = {norm_ff.sign, ONE_BITS[30:0]};
      end else begin
         samp_in = {norm_ff.sign, mag[30:0]};
      end
   end

   assign en2      = ~v2_ff | out_ready;
   assign en1      = ~v1_ff | en2;
   assign in_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         norm_ff <= norm_in;
      end
      if (en2) begin
         samp_ff <= samp_in;
      end
   end

   assign out_valid = v2_ff;
   assign samp      = samp_ff;

endmodule

FILE: hw/rtl/fpc_conv.sv
module fpc_conv
   import fpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  fmt_type     fmt,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [31:0] samp,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [31:0] pcm_word,
   output logic [2:0]  byte_count
);

   typedef struct packed {
      logic        sign;
      logic [7:0]  exp_eff;
      logic [39:0] n16;
      logic [49:0] a_fix;
      logic [31:0] word_s32;
      logic [31:0] word_f32;
   } c1_type;

   typedef struct packed {
      logic        sign;
      logic [7:0]  exp_eff;
      logic [40:0] n16_r;
      logic [50:0] a_r;
      logic [31:0] word_s32;
      logic [31:0] word_f32;
   } c2_type;

   typedef struct packed {
      logic [58:0] n8;
      logic [31:0] word_s16;
      logic [31:0] word_s32;
      logic [31:0] word_f32;
   } c3_type;

   logic        en1, en2, en3, en4;
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   c1_type      c1_ff, c1_in;
   c2_type      c2_ff, c2_in;
   c3_type      c3_ff, c3_in;
   logic [31:0] pcm_ff, pcm_in;
   logic [2:0]  bytes_ff, bytes_in;

   logic        ss;
   logic [7:0]  se;
   logic [23:0] sm;
   logic [7:0]  sx;
   logic [31:0] mag32;
   logic [49:0] s_fix;
   logic [40:0] trunc16;
   logic [15:0] t16;
   logic [63:0] n8_r;
   logic [7:0]  word_u8;

   // stage one: both 32-bit formats are finished here, scale products start here
   always_comb begin
      ss = samp[31];
      se = samp[30:23];
      sm = {(|se), samp[22:0]};
      sx = (se == 8'd0) ? 8'd1 : se;
      if (sx >= 8'd119) begin
         mag32 = 32'(sm) << 4'(sx - 8'd119);
      end else begin
         mag32 = 32'(sm) >> (8'd119 - sx);
      end
      if (sx >= 8'd102) begin
         s_fix = 50'(sm) << 5'(sx - 8'd102);
      end else begin
         s_fix = '0;
      end
      c1_in.sign     = ss;
      c1_in.exp_eff  = sx;
      c1_in.n16      = 40'(sm) * 40'(S16_SCALE);
      // s + 1 in fixed point with 48 fraction bits
      c1_in.a_fix    = ss ? ((50'd1 << 48) - s_fix) : ((50'd1 << 48) + s_fix);
      c1_in.word_s32 = (~ss & mag32[31]) ? S32_MAX : (ss ? (32'd0 - mag32) : mag32);
      c1_in.word_f32 = samp;
   end

   // stage two: round the 16-bit product and s + 1 to single precision
   always_comb begin
      c2_in.sign     = c1_ff.sign;
      c2_in.exp_eff  = c1_ff.exp_eff;
      c2_in.n16_r    = 41'(round_sig24(64'(c1_ff.n16)));
      c2_in.a_r      = 51'(round_sig24(64'(c1_ff.a_fix)));
      c2_in.word_s32 = c1_ff.word_s32;
      c2_in.word_f32 = c1_ff.word_f32;
   end

   // stage three: truncate the 16-bit result, scale s + 1 by 255
   always_comb begin
      trunc16        = c2_ff.n16_r >> (8'd150 - c2_ff.exp_eff);
      t16            = 16'(trunc16);
      c3_in.word_s16 = {16'b0, c2_ff.sign ? (16'd0 - t16) : t16};
      c3_in.n8       = (59'(c2_ff.a_r) << 8) - 59'(c2_ff.a_r);
      c3_in.word_s32 = c2_ff.word_s32;
      c3_in.word_f32 = c2_ff.word_f32;
   end

   // stage four: round the 8-bit product, truncate, pick the format
   always_comb begin
      n8_r    = round_sig24(64'(c3_ff.n8));
      word_u8 = 8'(n8_r >> 49);
      unique case (fmt)
         FMT_U8: begin
            pcm_in   = {24'b0, word_u8};
            bytes_in = 3'd1;
         end
         FMT_S16: begin
            pcm_in   = c3_ff.word_s16;
            bytes_in = 3'd2;
         end
         FMT_S32: begin
            pcm_in   = c3_ff.word_s32;
            bytes_in = 3'd4;
         end
         default: begin
            pcm_in   = c3_ff.word_f32;
            bytes_in = 3'd4;
         end
      endcase
   end

   assign en4      = ~v4_ff | out_ready;
   assign en3      = ~v3_ff | en4;
   assign en2      = ~v2_ff | en3;
   assign en1      = ~v1_ff | en2;
   assign in_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         c1_ff <= c1_in;
      end
      if (en2) begin
         c2_ff <= c2_in;
      end
      if (en3) begin
         c3_ff <= c3_in;
      end
      if (en4) begin
         pcm_ff   <= pcm_in;
         bytes_ff <= bytes_in;
      end
   end

   assign out_valid  = v4_ff;
   assign pcm_word   = pcm_ff;
   assign byte_count = bytes_ff;

   a_samp_clamped: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> (samp[30:0] <= ONE_BITS[30:0]))
      else $error("clamped sample outside unit range");

   a_u8_width: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && (fmt == FMT_U8)) |-> ((pcm_ff[31:8] == 24'd0) && (bytes_ff == 3'd1)))
      else $error("8-bit result wider than one byte");

   a_s16_width: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && (fmt == FMT_S16)) |-> ((pcm_ff[31:16] == 16'd0) && (bytes_ff == 3'd2)))
      else $error("16-bit result has upper bits set");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !out_ready) |=> (v4_ff && $stable(pcm_ff)))
      else $error("stalled result lost");

endmodule

FILE: hw/rtl/float_to_pcm_sample_converter.sv
// an item accepted on req_ch reaches rsp_ch through the multiply, normalise and convert stages
// throughput: one item per cycle while rsp_ch does not stall, fixed by the seven-stage pipeline
// a stalled rsp_ch backs up stage by stage, empty stages keep accepting
// reset (synchronous, active high) empties the pipeline, volume to 1.0,
// format to signed 16-bit
module float_to_pcm_sample_converter
   import fpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   fpc_req_if.sink                req_ch,
   fpc_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_wdata
);

   // configuration registers
   logic [31:0] volume_ff;
   fmt_type     format_ff;

   // pipeline hand-offs
   logic        mul_valid, mul_ready;
   prod_type    mul_prod;
   logic        norm_valid, norm_ready;
   logic [31:0] norm_samp;

   // register writes; the user must write only while no item is in flight, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff <= VOLUME_RESET;
         format_ff <= FORMAT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VOLUME: volume_ff <= csr_wdata[31:0];
            CSR_FORMAT: format_ff <= fmt_type'(csr_wdata[1:0]);
            default:    ;
         endcase
      end
   end

   // stage 1: decode and 24x24 significand multiply
   fpc_mul u_mul (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_ch.valid),
      .in_ready    (req_ch.ready),
      .sample_bits (req_ch.sample_bits),
      .volume_bits (volume_ff),
      .out_valid   (mul_valid),
      .out_ready   (mul_ready),
      .prod        (mul_prod)
   );

   // stages 2-3: normalise, round to nearest even, clamp to [-1, 1]
   fpc_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_ready  (mul_ready),
      .prod      (mul_prod),
      .out_valid (norm_valid),
      .out_ready (norm_ready),
      .samp      (norm_samp)
   );

   // stages 4-7: format conversion, last stage is the output register
   fpc_conv u_conv (
      .clock      (clock),
      .reset      (reset),
      .fmt        (format_ff),
      .in_valid   (norm_valid),
      .in_ready   (norm_ready),
      .samp       (norm_samp),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .pcm_word   (rsp_ch.pcm_word),
      .byte_count (rsp_ch.byte_count)
   );

endmodule

FILE: test/float_to_pcm_sample_converter_tb.sv
module float_to_pcm_sample_converter_tb;
   import fpc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 5000;
   localparam int TAIL_CYCLES = 20;

   // expected pcm words, with the single-precision arithmetic done in integers
   class pcm_scoreboard;
      logic [31:0] volume;
      fmt_type     fmt;
      logic [31:0] word_q[$];
      logic [2:0]  count_q[$];
      int          errors;

      function new();
         volume = VOLUME_RESET;
         fmt    = FORMAT_RESET;
         errors = 0;
      endfunction

      function int top_bit(input logic [127:0] n);
         int pos;
         pos = -1;
         for (int i = 0; i < 128; i++) begin
            if (n[i]) begin
               pos = i;
            end
         end
         return pos;
      endfunction

      // n >> sh, ties to even
      function logic [127:0] shift_rne(input logic [127:0] n, input int sh);
         logic [127:0] q;
         logic [127:0] rem;
         logic [127:0] half;
         if (sh <= 0) begin
            return n;
         end
         if (sh >= 120) begin
            return '0;
         end
         q    = n >> sh;
         rem  = n & ((128'd1 << sh) - 128'd1);
         half = 128'd1 << (sh - 1);
         if (rem > half || (rem == half && q[0])) begin
            q = q + 128'd1;
         end
         return q;
      endfunction

      // value n * 2^e rounded to 24 significant bits, normal range only
      function void round_sig(inout logic [127:0] n, inout int e);
         int sh;
         sh = top_bit(n) - 23;
         if (sh > 0) begin
            n = shift_rne(n, sh);
            e = e + sh;
         end
      endfunction

      // magnitude of n * 2^e truncated toward zero
      function logic [127:0] chop(input logic [127:0] n, input int e);
         if (e >= 0) begin
            return n << e;
         end
         if (-e >= 128) begin
            return '0;
         end
         return n >> (-e);
      endfunction

      function void unpack(input logic [31:0] f, output logic [127:0] m, output int e);
         if (f[30:23] == 8'd0) begin
            m = 128'(f[22:0]);
            e = -149;
         end else begin
            m = 128'({1'b1, f[22:0]});
            e = int'(f[30:23]) - 150;
         end
      endfunction

      function logic [31:0] mul_f32(input logic [31:0] a, input logic [31:0] b);
         logic         sg;
         logic         nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
         logic [127:0] ma, mb, n, m;
         int           ea, eb, e, q;
         sg     = a[31] ^ b[31];
         nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 0);
         nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 0);
         inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 0);
         inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 0);
         zero_a = (a[30:0] == 0);
         zero_b = (b[30:0] == 0);
         if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) begin
            return 32'h7FC0_0000;
         end
         if (inf_a || inf_b) begin
            return {sg, 8'hFF, 23'd0};
         end
         if (zero_a || zero_b) begin
            return {sg, 31'd0};
         end
         unpack(a, ma, ea);
         unpack(b, mb, eb);
         n = ma * mb;
         e = ea + eb;
         q = top_bit(n) + e - 23;
         if (q < -149) begin
            q = -149;
         end
         m = (q > e) ? shift_rne(n, q - e) : (n << (e - q));
         if (m == (128'd1 << 24)) begin
            m = 128'd1 << 23;
            q = q + 1;
         end
         if (m < (128'd1 << 23)) begin
            return {sg, 8'd0, m[22:0]};
         end
         if (q + 150 >= 255) begin
            return {sg, 8'hFF, 23'd0};
         end
         return {sg, 8'(q + 150), m[22:0]};
      endfunction

      function void predict(input logic [31:0] x, output logic [31:0] word,
                            output logic [2:0] count);
         logic [31:0]  p, s;
         logic [127:0] ms, n, mag;
         int           es, e;
         p = mul_f32(x, volume);
         // nan goes to -1, anything beyond unit magnitude saturates
         if (p[30:23] == 8'hFF && p[22:0] != 0) begin
            s = NEG_ONE_BITS;
         end else if (p[30:0] > ONE_BITS[30:0]) begin
            s = {p[31], ONE_BITS[30:0]};
         end else begin
            s = p;
         end
         unpack(s, ms, es);
         if (s[30:0] == 0) begin
            ms = '0;
         end
         case (fmt)
            FMT_U8: begin
               if (s[30:23] < 8'd97) begin
                  // s + 1 rounds to exactly 1, times 127.5 truncates to 127
                  word = 32'd127;
               end else begin
                  mag = ms << (es + 64);
                  n   = s[31] ? ((128'd1 << 64) - mag) : ((128'd1 << 64) + mag);
                  e   = -64;
                  round_sig(n, e);
                  n = n * 128'd255;
                  e = e - 1;
                  round_sig(n, e);
                  mag  = chop(n, e);
                  word = {24'd0, mag[7:0]};
               end
               count = 3'd1;
            end
            FMT_S16: begin
               n = ms * 128'(S16_SCALE);
               e = es;
               round_sig(n, e);
               mag  = chop(n, e);
               word = {16'd0, s[31] ? 16'(-mag[15:0]) : mag[15:0]};
               count = 3'd2;
            end
            FMT_S32: begin
               if (s == ONE_BITS) begin
                  word = S32_MAX;
               end else begin
                  mag  = chop(ms, es + 31);
                  word = s[31] ? 32'(-mag[31:0]) : mag[31:0];
               end
               count = 3'd4;
            end
            default: begin
               word  = s;
               count = 3'd4;
            end
         endcase
      endfunction

      function void note_sample(input logic [31:0] x);
         logic [31:0] word;
         logic [2:0]  count;
         predict(x, word, count);
         word_q.push_back(word);
         count_q.push_back(count);
      endfunction

      function void check_result(input logic [31:0] word, input logic [2:0] count);
         logic [31:0] exp_word;
         logic [2:0]  exp_count;
         if (word_q.size() == 0) begin
            $error("unexpected item: pcm_word %h byte_count %0d", word, count);
            errors++;
            return;
         end
         exp_word  = word_q.pop_front();
         exp_count = count_q.pop_front();
         if (word !== exp_word) begin
            $error("pcm_word: expected %h, got %h", exp_word, word);
            errors++;
         end
         if (count !== exp_count) begin
            $error("byte_count: expected %0d, got %0d", exp_count, count);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [31:0] csr_wdata;

   fpc_req_if req_ch();
   fpc_rsp_if rsp_ch();

   pcm_scoreboard sb;

   int idle_cycles;
   int rx_cycle;
   int rx_stall;
   int burst_left;

   float_to_pcm_sample_converter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // sample both channels at the edge where an item moves
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sb.note_sample(req_ch.sample_bits);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_result(rsp_ch.pcm_word, rsp_ch.byte_count);
         end
      end
   end

   // watchdog: counts cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: cycles through always ready, coin-flip and long-stall stretches
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_stall > 0) begin
         rx_stall      <= rx_stall - 1;
         rsp_ch.ready  <= 1'b0;
      end else begin
         case ((rx_cycle / 300) % 3)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));
            default: begin
               rsp_ch.ready <= 1'b1;
               if ($urandom_range(0, 15) == 0) begin
                  rx_stall <= $urandom_range(1, 20);
               end
            end
         endcase
      end
   end

   // hold the input channel idle until every expected item is back
   task automatic drain();
      req_ch.valid <= 1'b0;
      // let the monitor note the item accepted at the last edge
      @(posedge clock);
      while (sb.word_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // registers are only touched with the pipeline empty
   task automatic set_config(input logic [31:0] vol, input fmt_type fmt);
      drain();
      repeat (10) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_VOLUME;
      csr_wdata <= vol;
      @(posedge clock);
      // upper bits of the format write are junk, only the low two count
      csr_index <= CSR_FORMAT;
      csr_wdata <= {30'($urandom), fmt};
      @(posedge clock);
      csr_we <= 1'b0;
      sb.volume = vol;
      sb.fmt    = fmt;
   endtask

   // one item, valid stays high afterwards unless a gap follows
   task automatic send_sample(input logic [31:0] x);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 30);
      end
      burst_left--;
      req_ch.valid       <= 1'b1;
      req_ch.sample_bits <= x;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
   endtask

   function automatic logic [31:0] random_sample();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5:
            return {1'($urandom), 8'($urandom_range(96, 127)), 23'($urandom)};
         6, 7:
            // right around unit magnitude, either side of the clamp
            return {1'($urandom), 8'($urandom_range(126, 127)), 23'($urandom)};
         default:
            return $urandom;
      endcase
   endfunction

   logic [31:0] edge_samples[] = '{
      32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
      32'h3F00_0000, 32'hBF00_0000, 32'h3F7F_FFFF, 32'hBF7F_FFFF,
      32'h3F80_0001, 32'hBF80_0001, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
      32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
      32'h7F80_0001, 32'h0000_0001, 32'h8000_0001, 32'h007F_FFFF,
      32'h0080_0000, 32'h3800_0000, 32'hB800_0000, 32'h3B00_0000
   };

   // gain settings: unity, zero, signed zero, infinity, nan, extremes, odd values
   logic [31:0] volumes[] = '{
      32'h3F80_0000, 32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
      32'h7FC0_0000, 32'h7F7F_FFFF, 32'h0000_0001, 32'h3F00_0000,
      32'hC000_0000, 32'h3F7F_FFFF, 32'hFFFF_FFFF, 32'h4700_0000
   };

   initial begin
      int pause_at;
      fmt_type fmt;
      sb = new();
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_VOLUME;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.sample_bits = '0;
      rsp_ch.ready       = 1'b0;
      idle_cycles        = 0;
      rx_cycle           = 0;
      rx_stall           = 0;
      burst_left         = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings first, then the edge samples through every format
      foreach (edge_samples[i]) send_sample(edge_samples[i]);
      for (int f = 0; f < 4; f++) begin
         set_config(VOLUME_RESET, fmt_type'(f));
         foreach (edge_samples[i]) send_sample(edge_samples[i]);
      end

      // random part: every gain setting, formats rotating
      for (int ph = 0; ph < 16; ph++) begin
         fmt = fmt_type'(ph % 4);
         if (ph < volumes.size()) begin
            set_config(volumes[ph], fmt);
         end else begin
            set_config({1'($urandom), 8'($urandom_range(120, 132)), 23'($urandom)}, fmt);
         end
         pause_at = $urandom_range(10, 90);
         for (int i = 0; i < 100; i++) begin
            if (i == pause_at) begin
               drain();
            end
            send_sample(random_sample());
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.word_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
